// ===== hdl/pmm_pkg.sv =====
// Shared types and codes for the picture buffer mask manager.
package pmm_pkg;

   // Field widths fixed by the command and result formats
   localparam int CMD_W  = 3;
   localparam int IDX_W  = 5;
   localparam int CNT_W  = 6;
   localparam int DATA_W = 32;
   localparam int MASK_W = 32;

   // Default table depth
   localparam int DEFAULT_MAX_BUFFERS = 32;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_LOAD     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_BUSY     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_FREE     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_PUBLISH  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RETRIEVE = 3'd4;

   // Command broadcast to every slot cell
   typedef struct packed {
      logic              go;
      logic [CMD_W-1:0]  command;
      logic              sel_client;
      logic [IDX_W-1:0]  entry_index;
      logic [DATA_W-1:0] frame_address;
      logic [DATA_W-1:0] frame_metadata;
      logic [CNT_W-1:0]  active_count;
   } bcast_type;

   // Priority link handed from one cell to the next
   typedef struct packed {
      logic              claim;
      logic [IDX_W-1:0]  index;
      logic [DATA_W-1:0] address;
      logic [DATA_W-1:0] metadata;
   } link_type;

endpackage

// ===== hdl/pmm_cell.sv =====
// One table slot: address, metadata and its two ownership bits.
module pmm_cell #(
   parameter int SLOT = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  pmm_pkg::bcast_type bcast,
   input  pmm_pkg::link_type  link_in,
   output pmm_pkg::link_type  link_out,
   output logic               client_bit,
   output logic               hw_next
);

   logic [pmm_pkg::DATA_W-1:0] address_ff, address_in;
   logic [pmm_pkg::DATA_W-1:0] metadata_ff, metadata_in;
   logic                       client_ff, client_in;
   logic                       hw_ff, hw_in;
   logic                       active;
   logic                       match;
   logic                       candidate;
   logic                       win;

   // Slot is inside the active window
   assign active = pmm_pkg::CNT_W'(SLOT) < bcast.active_count;
   assign match  = bcast.frame_address == address_ff;

   // This slot wants the command; lower slots take precedence via the link
   always_comb begin
      candidate = 1'b0;
      if (bcast.go && active) begin
         if (bcast.command == pmm_pkg::CMD_BUSY || bcast.command == pmm_pkg::CMD_FREE) begin
            candidate = match;
         end else if (bcast.command == pmm_pkg::CMD_RETRIEVE) begin
            candidate = bcast.sel_client ? client_ff : hw_ff;
         end
      end
   end

   assign win = candidate && !link_in.claim;

   // Pass the winner toward the end of the row
   always_comb begin
      link_out.claim    = link_in.claim | candidate;
      link_out.index    = win ? pmm_pkg::IDX_W'(SLOT) : link_in.index;
      link_out.address  = win ? address_ff : link_in.address;
      link_out.metadata = win ? metadata_ff : link_in.metadata;
   end

   // Slot update
   always_comb begin
      address_in  = address_ff;
      metadata_in = metadata_ff;
      client_in   = client_ff;
      hw_in       = hw_ff;
      if (bcast.go) begin
         unique case (bcast.command)
            pmm_pkg::CMD_LOAD: begin
               if (bcast.entry_index == pmm_pkg::IDX_W'(SLOT)) begin
                  address_in  = bcast.frame_address;
                  metadata_in = bcast.frame_metadata;
               end
            end
            pmm_pkg::CMD_BUSY: begin
               if (win) hw_in = 1'b0;
            end
            pmm_pkg::CMD_FREE: begin
               if (win) begin
                  client_in   = 1'b1;
                  metadata_in = bcast.frame_metadata;
               end
            end
            pmm_pkg::CMD_PUBLISH: begin
               hw_in     = hw_ff | client_ff;
               client_in = 1'b0;
            end
            pmm_pkg::CMD_RETRIEVE: begin
               if (win) begin
                  if (bcast.sel_client) client_in = 1'b0;
                  else                  hw_in     = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Entry payload, no reset
   always_ff @(posedge clock) begin
      address_ff  <= address_in;
      metadata_ff <= metadata_in;
   end

   // Ownership bits
   always_ff @(posedge clock) begin
      if (reset) begin
         client_ff <= 1'b0;
         hw_ff     <= 1'b0;
      end else begin
         client_ff <= client_in;
         hw_ff     <= hw_in;
      end
   end

   assign client_bit = client_ff;
   assign hw_next    = hw_in;

endmodule

// ===== hdl/picture_buffer_mask_manager.sv =====
// Channel   | Handshake                  | Payload
// ----------+----------------------------+-------------------------------------------
// command   | start / busy               | req_command, req_entry_index,
//           |                            | req_frame_address, req_frame_metadata
// result    | rsp_strobe (one cycle)     | rsp_status, rsp_found, rsp_found_index,
//           |                            | rsp_out_address, rsp_out_metadata,
//           |                            | rsp_release_mask
// config    | csr_valid / csr_ready      | csr_data (buffer_count)
//
// A command is latched, and busy raised, at the edge that takes start; while busy is high
// the lookup runs down the row of slot cells and the result is registered as busy drops;
// rsp_strobe is high in the cycle after busy, when busy is already low again.
// The lowest-slot priority ripples through one cell per slot within the execute cycle.
// Reset (synchronous) clears both masks, the count and the handshake; table contents
// stay undefined until loaded. The receiver cannot stall, csr_ready is always high.
module picture_buffer_mask_manager #(
   parameter int MAX_BUFFERS = pmm_pkg::DEFAULT_MAX_BUFFERS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [pmm_pkg::CMD_W-1:0]  req_command,
   input  logic [pmm_pkg::IDX_W-1:0]  req_entry_index,
   input  logic [pmm_pkg::DATA_W-1:0] req_frame_address,
   input  logic [pmm_pkg::DATA_W-1:0] req_frame_metadata,
   output logic                       rsp_strobe,
   output logic                       rsp_status,
   output logic                       rsp_found,
   output logic [pmm_pkg::IDX_W-1:0]  rsp_found_index,
   output logic [pmm_pkg::DATA_W-1:0] rsp_out_address,
   output logic [pmm_pkg::DATA_W-1:0] rsp_out_metadata,
   output logic [pmm_pkg::MASK_W-1:0] rsp_release_mask,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [pmm_pkg::CNT_W-1:0]  csr_data
);

   logic                       pending_ff;
   logic [pmm_pkg::CMD_W-1:0]  command_ff;
   logic [pmm_pkg::IDX_W-1:0]  entry_index_ff;
   logic [pmm_pkg::DATA_W-1:0] frame_address_ff;
   logic [pmm_pkg::DATA_W-1:0] frame_metadata_ff;
   logic [pmm_pkg::CNT_W-1:0]  buffer_count_ff;
   logic [pmm_pkg::CNT_W-1:0]  active_count;
   logic                       accept;

   logic                       strobe_ff;
   logic                       status_ff, status_in;
   logic                       found_ff, found_in;
   logic [pmm_pkg::IDX_W-1:0]  found_index_ff, found_index_in;
   logic [pmm_pkg::DATA_W-1:0] address_ff, address_in;
   logic [pmm_pkg::DATA_W-1:0] metadata_ff, metadata_in;
   logic [pmm_pkg::MASK_W-1:0] release_ff, release_in;

   pmm_pkg::bcast_type         bcast;
   pmm_pkg::link_type          link [MAX_BUFFERS+1];
   logic [MAX_BUFFERS-1:0]     client_bits;
   logic [MAX_BUFFERS-1:0]     hw_next;
   logic                       lookup_cmd;

   assign accept    = start && !pending_ff;
   assign busy      = pending_ff;
   assign csr_ready = 1'b1;

   // Count register; the count used by the cells is saturated at the table depth
   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_count_ff <= '0;
      end else if (csr_valid) begin
         buffer_count_ff <= csr_data;
      end
   end

   assign active_count = (buffer_count_ff > pmm_pkg::CNT_W'(MAX_BUFFERS)) ?
                         pmm_pkg::CNT_W'(MAX_BUFFERS) : buffer_count_ff;

   // Command beat capture
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
      end else begin
         pending_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         command_ff        <= req_command;
         entry_index_ff    <= req_entry_index;
         frame_address_ff  <= req_frame_address;
         frame_metadata_ff <= req_frame_metadata;
      end
   end

   // Broadcast to the cells
   always_comb begin
      bcast.go             = pending_ff;
      bcast.command        = command_ff;
      bcast.sel_client     = |client_bits;
      bcast.entry_index    = entry_index_ff;
      bcast.frame_address  = frame_address_ff;
      bcast.frame_metadata = frame_metadata_ff;
      bcast.active_count   = active_count;
   end

   assign link[0] = '0;

   // Row of slot cells, lowest slot first
   for (genvar i = 0; i < MAX_BUFFERS; i++) begin : g_cell
      pmm_cell #(
         .SLOT(i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .bcast      (bcast),
         .link_in    (link[i]),
         .link_out   (link[i+1]),
         .client_bit (client_bits[i]),
         .hw_next    (hw_next[i])
      );
   end

   assign lookup_cmd = command_ff == pmm_pkg::CMD_BUSY || command_ff == pmm_pkg::CMD_FREE;

   // Result formatting
   always_comb begin
      found_in       = link[MAX_BUFFERS].claim;
      status_in      = lookup_cmd && !found_in;
      found_index_in = link[MAX_BUFFERS].index;
      if (command_ff == pmm_pkg::CMD_FREE) begin
         address_in  = found_in ? frame_address_ff : '0;
         metadata_in = found_in ? frame_metadata_ff : '0;
      end else begin
         address_in  = link[MAX_BUFFERS].address;
         metadata_in = link[MAX_BUFFERS].metadata;
      end
      release_in = '0;
      for (int i = 0; i < MAX_BUFFERS; i++) begin
         release_in[i] = hw_next[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= pending_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pending_ff) begin
         status_ff      <= status_in;
         found_ff       <= found_in;
         found_index_ff <= found_index_in;
         address_ff     <= address_in;
         metadata_ff    <= metadata_in;
         release_ff     <= release_in;
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_found        = found_ff;
   assign rsp_found_index  = found_index_ff;
   assign rsp_out_address  = address_ff;
   assign rsp_out_metadata = metadata_ff;
   assign rsp_release_mask = release_ff;

endmodule

// ===== tb/pmm_checker.sv =====
// Watches the command, result and config channels of the picture buffer mask
// manager, predicts every result beat and compares it field by field.
module pmm_checker #(
   parameter int MAX_BUFFERS = pmm_pkg::DEFAULT_MAX_BUFFERS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  logic [pmm_pkg::CMD_W-1:0]  req_command,
   input  logic [pmm_pkg::IDX_W-1:0]  req_entry_index,
   input  logic [pmm_pkg::DATA_W-1:0] req_frame_address,
   input  logic [pmm_pkg::DATA_W-1:0] req_frame_metadata,
   input  logic                       rsp_strobe,
   input  logic                       rsp_status,
   input  logic                       rsp_found,
   input  logic [pmm_pkg::IDX_W-1:0]  rsp_found_index,
   input  logic [pmm_pkg::DATA_W-1:0] rsp_out_address,
   input  logic [pmm_pkg::DATA_W-1:0] rsp_out_metadata,
   input  logic [pmm_pkg::MASK_W-1:0] rsp_release_mask,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [pmm_pkg::CNT_W-1:0]  csr_data,
   output int unsigned                outstanding,
   output int unsigned                mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                       status;
      logic                       found;
      logic [pmm_pkg::IDX_W-1:0]  found_index;
      logic [pmm_pkg::DATA_W-1:0] out_address;
      logic [pmm_pkg::DATA_W-1:0] out_metadata;
      logic [pmm_pkg::MASK_W-1:0] release_mask;
   } buf_result_type;

   // Shadow of the buffer table, ownership masks and buffer count
   logic [pmm_pkg::DATA_W-1:0] addr_tbl [MAX_BUFFERS];
   logic [pmm_pkg::DATA_W-1:0] meta_tbl [MAX_BUFFERS];
   logic [pmm_pkg::MASK_W-1:0] returned_mask;
   logic [pmm_pkg::MASK_W-1:0] hw_mask;
   logic [pmm_pkg::CNT_W-1:0]  count_reg;

   buf_result_type expected_results [$];
   int unsigned fails = 0;

   // Applies one command to the shadow state and returns the result it gives
   function automatic buf_result_type execute_command(
         input logic [pmm_pkg::CMD_W-1:0]  cmd,
         input logic [pmm_pkg::IDX_W-1:0]  idx,
         input logic [pmm_pkg::DATA_W-1:0] addr,
         input logic [pmm_pkg::DATA_W-1:0] meta);
      buf_result_type             r;
      int                         lim;
      int                         hit;
      logic                       use_client;
      logic [pmm_pkg::MASK_W-1:0] pick;
      r   = '0;
      hit = -1;
      // counts above the table depth saturate
      lim = (count_reg > MAX_BUFFERS) ? MAX_BUFFERS : int'(count_reg);
      case (cmd)
         pmm_pkg::CMD_LOAD: begin
            if (idx < MAX_BUFFERS) begin
               addr_tbl[idx] = addr;
               meta_tbl[idx] = meta;
            end
         end
         pmm_pkg::CMD_BUSY, pmm_pkg::CMD_FREE: begin
            // lowest matching slot wins
            for (int i = 0; i < lim && hit < 0; i++)
               if (addr_tbl[i] == addr) hit = i;
            if (hit < 0) begin
               r.status = 1'b1;
            end else begin
               r.found       = 1'b1;
               r.found_index = pmm_pkg::IDX_W'(hit);
               if (cmd == pmm_pkg::CMD_BUSY) begin
                  hw_mask[hit]   = 1'b0;
                  r.out_address  = addr_tbl[hit];
                  r.out_metadata = meta_tbl[hit];
               end else begin
                  returned_mask[hit] = 1'b1;
                  meta_tbl[hit]      = meta;
                  r.out_address      = addr;
                  r.out_metadata     = meta;
               end
            end
         end
         pmm_pkg::CMD_PUBLISH: begin
            hw_mask       = hw_mask | returned_mask;
            returned_mask = '0;
         end
         pmm_pkg::CMD_RETRIEVE: begin
            // client mask has priority; only bits below the count qualify
            use_client = (returned_mask != '0);
            pick       = use_client ? returned_mask : hw_mask;
            for (int i = 0; i < lim && hit < 0; i++)
               if (pick[i]) hit = i;
            if (hit >= 0) begin
               pick[hit] = 1'b0;
               if (use_client) returned_mask = pick;
               else hw_mask = pick;
               r.found        = 1'b1;
               r.found_index  = pmm_pkg::IDX_W'(hit);
               r.out_address  = addr_tbl[hit];
               r.out_metadata = meta_tbl[hit];
            end
         end
         default: ;
      endcase
      r.release_mask = hw_mask;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [pmm_pkg::DATA_W-1:0] want,
                              input logic [pmm_pkg::DATA_W-1:0] got);
      if (want !== got) begin
         fails++;
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
      end
   endtask

   // Sample the channels at each edge: config, result beat, then new command
   always @(posedge clock) begin
      buf_result_type want;
      if (reset) begin
         returned_mask = '0;
         hw_mask       = '0;
         count_reg     = '0;
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) count_reg = csr_data;
         if (rsp_strobe) begin
            if (expected_results.size() == 0) begin
               fails++;
               $display("%0t: result beat with nothing expected, expected none, got %h",
                        $time, rsp_out_address);
            end else begin
               want = expected_results.pop_front();
               check_field("status", pmm_pkg::DATA_W'(want.status),
                           pmm_pkg::DATA_W'(rsp_status));
               check_field("found", pmm_pkg::DATA_W'(want.found),
                           pmm_pkg::DATA_W'(rsp_found));
               check_field("found_index", pmm_pkg::DATA_W'(want.found_index),
                           pmm_pkg::DATA_W'(rsp_found_index));
               check_field("out_address", want.out_address, rsp_out_address);
               check_field("out_metadata", want.out_metadata, rsp_out_metadata);
               check_field("release_mask", want.release_mask, rsp_release_mask);
            end
         end
         if (start && !busy)
            expected_results.push_back(execute_command(req_command, req_entry_index,
                                                       req_frame_address,
                                                       req_frame_metadata));
      end
      outstanding    <= expected_results.size();
      mismatch_count <= fails;
   end

endmodule

// ===== tb/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_SLOTS   = pmm_pkg::DEFAULT_MAX_BUFFERS;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 88;

   // Command codes the block treats as no-ops
   localparam logic [pmm_pkg::CMD_W-1:0] CMD_RESERVED_FIRST = 3'd5;
   localparam logic [pmm_pkg::CMD_W-1:0] CMD_RESERVED_LAST  = 3'd7;

   // Never loaded into the table, so lookups on it miss
   localparam logic [pmm_pkg::DATA_W-1:0] ABSENT_ADDR = 32'hDEAD_0001;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic [pmm_pkg::CMD_W-1:0]  req_command = '0;
   logic [pmm_pkg::IDX_W-1:0]  req_entry_index = '0;
   logic [pmm_pkg::DATA_W-1:0] req_frame_address = '0;
   logic [pmm_pkg::DATA_W-1:0] req_frame_metadata = '0;
   logic                       rsp_strobe;
   logic                       rsp_status;
   logic                       rsp_found;
   logic [pmm_pkg::IDX_W-1:0]  rsp_found_index;
   logic [pmm_pkg::DATA_W-1:0] rsp_out_address;
   logic [pmm_pkg::DATA_W-1:0] rsp_out_metadata;
   logic [pmm_pkg::MASK_W-1:0] rsp_release_mask;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [pmm_pkg::CNT_W-1:0]  csr_data = '0;

   int unsigned outstanding;
   int unsigned mismatch_count;

   // Stimulus bookkeeping: addresses loaded per slot, current count
   logic [pmm_pkg::DATA_W-1:0] slot_addr [MAX_SLOTS];
   logic [pmm_pkg::CNT_W-1:0]  cur_count = '0;
   int unsigned                commands_sent = 0;
   int unsigned                count_writes = 0;
   int unsigned                cycles = 0;
   bit                         allow_gaps = 1'b1;

   always #10 clock = ~clock;

   picture_buffer_mask_manager #(.MAX_BUFFERS(MAX_SLOTS)) i_dut (.*);

   pmm_checker #(.MAX_BUFFERS(MAX_SLOTS)) i_checker (.*);

   // Run guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
         $display("Mismatches found");
         $finish;
      end
   end

   // Present one command beat, hold it until taken, then maybe idle a while
   task automatic send_command(input logic [pmm_pkg::CMD_W-1:0]  cmd,
                               input logic [pmm_pkg::IDX_W-1:0]  idx,
                               input logic [pmm_pkg::DATA_W-1:0] addr,
                               input logic [pmm_pkg::DATA_W-1:0] meta);
      int r;
      int gap;
      req_command        <= cmd;
      req_entry_index    <= idx;
      req_frame_address  <= addr;
      req_frame_metadata <= meta;
      start              <= 1'b1;
      do @(posedge clock); while (busy);
      commands_sent++;
      if (cmd == pmm_pkg::CMD_LOAD) slot_addr[idx] = addr;
      // mostly short gaps, a few long ones
      r = $urandom_range(0, 99);
      if (!allow_gaps || r < 40) gap = 0;
      else if (r < 85) gap = $urandom_range(1, 3);
      else if (r < 97) gap = $urandom_range(4, 10);
      else gap = $urandom_range(20, 40);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle;
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0 || busy);
   endtask

   task automatic write_count(input logic [pmm_pkg::CNT_W-1:0] value);
      wait_idle();
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      cur_count = value;
      count_writes++;
   endtask

   // Random command, addresses mostly taken from loaded slots in the active range
   task automatic random_command;
      int                         r;
      int                         lim;
      int                         slot;
      logic [pmm_pkg::CMD_W-1:0]  cmd;
      logic [pmm_pkg::DATA_W-1:0] addr;
      lim  = (cur_count > MAX_SLOTS) ? MAX_SLOTS : int'(cur_count);
      slot = (lim > 0 && $urandom_range(0, 4) != 0) ? $urandom_range(0, lim - 1)
                                                     : $urandom_range(0, MAX_SLOTS - 1);
      addr = ($urandom_range(0, 3) == 0) ? pmm_pkg::DATA_W'($urandom()) : slot_addr[slot];
      r    = $urandom_range(0, 99);
      if (r < 12) cmd = pmm_pkg::CMD_LOAD;
      else if (r < 34) cmd = pmm_pkg::CMD_BUSY;
      else if (r < 64) cmd = pmm_pkg::CMD_FREE;
      else if (r < 78) cmd = pmm_pkg::CMD_PUBLISH;
      else if (r < 95) cmd = pmm_pkg::CMD_RETRIEVE;
      else cmd = CMD_CMD_W_RESERVED();
      send_command(cmd, pmm_pkg::IDX_W'($urandom_range(0, MAX_SLOTS - 1)), addr,
                   pmm_pkg::DATA_W'($urandom()));
   endtask

   function automatic logic [pmm_pkg::CMD_W-1:0] CMD_CMD_W_RESERVED();
      return pmm_pkg::CMD_W'($urandom_range(CMD_RESERVED_FIRST, CMD_RESERVED_LAST));
   endfunction

   initial begin
      logic [pmm_pkg::CNT_W-1:0]  phase_counts [8];
      logic [pmm_pkg::DATA_W-1:0] addr;
      logic [pmm_pkg::DATA_W-1:0] meta;
      phase_counts = '{6'd32, 6'd63, 6'd1, 6'd0, 6'd17, 6'd33, 6'd31, 6'd32};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Load every slot first so no lookup ever reads an unwritten entry;
      // slot 5 duplicates slot 3, slots 0 and 31 hold the extreme values
      for (int i = 0; i < MAX_SLOTS; i++) begin
         if (i == 0) addr = '0;
         else if (i == MAX_SLOTS - 1) addr = '1;
         else if (i == 5) addr = slot_addr[3];
         else addr = {8'(i), 24'($urandom())};
         if (i == 0) meta = '0;
         else if (i == MAX_SLOTS - 1) meta = '1;
         else meta = pmm_pkg::DATA_W'($urandom());
         send_command(pmm_pkg::CMD_LOAD, pmm_pkg::IDX_W'(i), addr, meta);
      end

      // Directed: zero count, hits and misses, duplicates, both mask paths
      send_command(pmm_pkg::CMD_BUSY, '0, '0, '0);
      send_command(pmm_pkg::CMD_RETRIEVE, '0, '0, '0);
      write_count(6'd32);
      send_command(pmm_pkg::CMD_FREE, '0, '0, '1);
      send_command(pmm_pkg::CMD_FREE, '1, '1, '0);
      send_command(pmm_pkg::CMD_FREE, '0, slot_addr[3], 32'h5A5A_A5A5);
      send_command(pmm_pkg::CMD_FREE, '0, ABSENT_ADDR, '1);
      send_command(pmm_pkg::CMD_BUSY, '0, ABSENT_ADDR, '0);
      send_command(pmm_pkg::CMD_RETRIEVE, '0, '0, '0);
      send_command(pmm_pkg::CMD_PUBLISH, '0, '0, '0);
      send_command(pmm_pkg::CMD_BUSY, '0, '1, '0);
      send_command(pmm_pkg::CMD_RETRIEVE, '0, '0, '0);
      send_command(pmm_pkg::CMD_RETRIEVE, '0, '0, '0);
      for (int c = CMD_RESERVED_FIRST; c <= CMD_RESERVED_LAST; c++)
         send_command(pmm_pkg::CMD_W'(c), '1, '1, '1);
      send_command(pmm_pkg::CMD_FREE, '0, '1, 32'h0F0F_F0F0);
      // client bit only above the count: retrieve finds nothing
      write_count(6'd2);
      send_command(pmm_pkg::CMD_RETRIEVE, '0, '0, '0);
      send_command(pmm_pkg::CMD_PUBLISH, '0, '0, '0);
      // count above the table depth saturates
      write_count(6'd63);
      send_command(pmm_pkg::CMD_RETRIEVE, '0, '0, '0);
      send_command(pmm_pkg::CMD_BUSY, '0, '1, '0);

      // Random phases, one per count setting; the next to last has no gaps
      for (int ph = 0; ph < 8; ph++) begin
         write_count(phase_counts[ph]);
         allow_gaps = (ph != 6);
         repeat (PHASE_ITEMS) random_command();
      end
      allow_gaps = 1'b1;

      wait_idle();
      repeat (10) @(posedge clock);
      $display("Sent %0d commands (all codes, hits, misses, duplicate addresses)", commands_sent);
      $display("Buffer count written %0d times, from 0 up to 63", count_writes);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
